### hdl/jes3_pkg.sv
`timescale 1ns / 1ps

package jes3_pkg;

  localparam int DW = 64;
  localparam int WW = 2 * DW;
  localparam int PAW = 3;

  localparam logic [DW-1:0] MAG_SAT = 64'd1 << 62;
  localparam logic signed [DW-1:0] ENT_LIM = (64'sd1 <<< 45) - 64'sd1;
  localparam logic signed [DW-1:0] VEC_LIM = 64'sd1 <<< 40;
  localparam logic signed [DW-1:0] VEC_ONE = 64'sd1 <<< 30;
  localparam logic signed [DW-1:0] OUT_LIM = 64'sd2147483647;
  localparam logic [DW-1:0] NORM_LO = 64'd1 << 44;
  localparam logic [DW-1:0] NORM_HI = 64'd1 << 45;
  localparam logic signed [WW-1:0] RND_VEC = 128'sd1 <<< 29;
  localparam logic signed [DW-1:0] RND_OUT = 64'sd128;

  localparam logic REG_TOL = 1'b0;
  localparam logic REG_SWEEPS = 1'b1;
  localparam logic [5:0] SWEEPS_RST = 6'd16;

  // rotation pairs (1,0), (2,0), (2,1); k is the index left over
  function automatic logic [1:0] pair_i(input logic [1:0] p);
    return (p == 2'd0) ? 2'd1 : 2'd2;
  endfunction

  function automatic logic [1:0] pair_j(input logic [1:0] p);
    return (p == 2'd2) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] pair_k(input logic [1:0] p);
    return (p == 2'd0) ? 2'd2 : ((p == 2'd1) ? 2'd1 : 2'd0);
  endfunction

endpackage

### hdl/jes3_mul.sv
`timescale 1ns / 1ps

module jes3_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [jes3_pkg::DW-1:0] a,
  input  logic signed [jes3_pkg::DW-1:0] b,
  output logic                          done,
  output logic [jes3_pkg::WW-1:0]       p
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t st;
  logic [jes3_pkg::DW-1:0] am, bm;
  logic neg;
  logic [1:0] cnt;
  logic [jes3_pkg::WW-1:0] acc;
  logic [31:0] opa, opb;
  logic [63:0] pp;
  logic [jes3_pkg::WW-1:0] pp_sh;

  always_comb begin
    opa = cnt[0] ? am[63:32] : am[31:0];
    opb = cnt[1] ? bm[63:32] : bm[31:0];
    pp = opa * opb;
    case (cnt)
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= M_IDLE;
      done <= 1'b0;
      cnt <= 2'd0;
    end else begin
      done <= 1'b0;
      case (st)
        M_IDLE: begin
          if (start) begin
            am <= a[63] ? (~a + 64'd1) : a;
            bm <= b[63] ? (~b + 64'd1) : b;
            neg <= a[63] ^ b[63];
            acc <= '0;
            cnt <= 2'd0;
            st <= M_RUN;
          end
        end
        M_RUN: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) st <= M_FIN;
        end
        M_FIN: begin
          p <= neg ? (~acc + 128'd1) : acc;
          done <= 1'b1;
          st <= M_IDLE;
        end
        default: st <= M_IDLE;
      endcase
    end
  end

endmodule

### hdl/jes3_div.sv
`timescale 1ns / 1ps

module jes3_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [jes3_pkg::WW-1:0]        n,
  input  logic [jes3_pkg::DW-1:0]        d,
  output logic                           done,
  output logic signed [jes3_pkg::DW-1:0] quo
);

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIN} dstate_t;

  dstate_t st;
  logic [jes3_pkg::WW-1:0] num, q;
  logic [jes3_pkg::DW-1:0] dm, r, qm;
  logic neg, dz;
  logic [6:0] cnt;
  logic [64:0] rs, diff;
  logic ge;

  always_comb begin
    rs = {r, num[127]};
    diff = rs - {1'b0, dm};
    ge = rs >= {1'b0, dm};
    if (q[127:64] != 64'd0) qm = jes3_pkg::MAG_SAT;
    else if (q[63:0] > jes3_pkg::MAG_SAT) qm = jes3_pkg::MAG_SAT;
    else qm = q[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= D_IDLE;
      done <= 1'b0;
      cnt <= 7'd0;
    end else begin
      done <= 1'b0;
      case (st)
        D_IDLE: begin
          if (start) begin
            num <= n[127] ? (~n + 128'd1) : n;
            dm <= d[63] ? (~d + 64'd1) : d;
            neg <= n[127] ^ d[63];
            dz <= (d == 64'd0);
            st <= D_PREP;
          end
        end
        D_PREP: begin
          num <= num + {65'd0, dm[63:1]};
          r <= '0;
          q <= '0;
          cnt <= 7'd0;
          st <= D_RUN;
        end
        D_RUN: begin
          num <= {num[126:0], 1'b0};
          if (ge) begin
            r <= diff[63:0];
            q <= {q[126:0], 1'b1};
          end else begin
            r <= rs[63:0];
            q <= {q[126:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) st <= D_FIN;
        end
        D_FIN: begin
          if (dz) quo <= '0;
          else quo <= neg ? $signed(~qm + 64'd1) : $signed(qm);
          done <= 1'b1;
          st <= D_IDLE;
        end
        default: st <= D_IDLE;
      endcase
    end
  end

endmodule

### hdl/jes3_sqrt.sv
`timescale 1ns / 1ps

module jes3_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [jes3_pkg::WW-1:0] n,
  output logic                    done,
  output logic [jes3_pkg::DW-1:0] root
);

  typedef enum logic {Q_IDLE, Q_RUN} qstate_t;

  qstate_t st;
  logic [jes3_pkg::WW-1:0] num;
  logic [65:0] rem;
  logic [5:0] cnt;
  logic [67:0] rs, trial, diff;

  always_comb begin
    rs = {rem, num[127:126]};
    trial = {2'b00, root, 2'b01};
    diff = rs - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= Q_IDLE;
      done <= 1'b0;
      cnt <= 6'd0;
    end else begin
      done <= 1'b0;
      case (st)
        Q_IDLE: begin
          if (start) begin
            num <= n;
            rem <= '0;
            root <= '0;
            cnt <= 6'd0;
            st <= Q_RUN;
          end
        end
        Q_RUN: begin
          num <= {num[125:0], 2'b00};
          if (rs >= trial) begin
            rem <= diff[65:0];
            root <= {root[62:0], 1'b1};
          end else begin
            rem <= rs[65:0];
            root <= {root[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            done <= 1'b1;
            st <= Q_IDLE;
          end
        end
        default: st <= Q_IDLE;
      endcase
    end
  end

endmodule

### hdl/jacobi_eigen_sym3.sv
`timescale 1ns / 1ps
// Eigenvalues and unit eigenvectors of a symmetric 3x3 matrix by cyclic
// Jacobi sweeps over the pairs (1,0), (2,0), (2,1).
// Input channel: the six distinct entries in signed Q16.16, one transfer per
// matrix. in_stall is high from the transfer until the last result has been
// placed in the output register, so one matrix is worked on at a time.
// Output channel: three transfers per matrix, pair_index 0, 1, 2, each with
// the eigenvalue (Q16.16, saturated), the eigenvector row (Q2.30) and the
// converged flag; last marks the third. While out_stall is high the output
// register holds its result and the sequencer waits.
// A pair below the tolerance is skipped; a rotation is mostly the bit-serial
// divider (three quotients per rotation), two square roots, 22 products on
// the shared 32x32 multiplier and the normalize shifts.
// A matrix is one input transfer, up to max_sweeps sweeps of the three pairs
// (at most max_sweeps * 3 rotations; a sweep in which no pair rotates ends
// the work) and the three result transfers.
// Reset clears the sequencer and output valid, sets off_diag_tolerance to 0
// and max_sweeps to 16. The user writes the registers over the APB port at
// 0 and 4 only while no matrix is in flight; the block does not enforce it.

module jacobi_eigen_sym3 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] entry_00,
  input  logic signed [31:0] entry_11,
  input  logic signed [31:0] entry_22,
  input  logic signed [31:0] entry_01,
  input  logic signed [31:0] entry_02,
  input  logic signed [31:0] entry_12,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         pair_index,
  output logic signed [31:0] eigenvalue,
  output logic signed [31:0] vector_x,
  output logic signed [31:0] vector_y,
  output logic signed [31:0] vector_z,
  output logic               converged,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [jes3_pkg::PAW-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_CHECK, S_DD_GO, S_DD_W, S_TT_GO, S_TT_W, S_SQ1_GO, S_SQ1_W,
    S_AA_GO, S_AA_W, S_BB_GO, S_BB_W, S_EIG, S_DIV1_GO, S_DIV1_W, S_VEC, S_NORM,
    S_VV1_GO, S_VV1_W, S_VV2_GO, S_VV2_W, S_SQ2_GO, S_SQ2_W, S_DC_GO, S_DC_W,
    S_DS_GO, S_DS_W, S_CA_GO, S_CA_W, S_CB_GO, S_CB_W, S_CRND, S_COMMIT, S_NEXT,
    S_OUT
  } state_t;

  localparam int DW = jes3_pkg::DW;
  localparam int WW = jes3_pkg::WW;

  state_t state;
  logic [30:0] tol;
  logic [5:0] max_sweeps;
  logic [5:0] sw;
  logic [1:0] pair, ok;
  logic [2:0] cq;
  logic any, conv;

  logic signed [DW-1:0] dg [3];
  logic signed [DW-1:0] od [3];
  logic signed [DW-1:0] ev [3][3];
  logic signed [DW-1:0] wi [3];
  logic signed [DW-1:0] wj [3];
  logic signed [DW-1:0] aii, ajj, aij, aik, ajk;
  logic signed [DW-1:0] d, t, tr, disc, li, lj, v1, v2, nrm, c, s, tmp;
  logic gt;
  logic signed [WW-1:0] acc;

  logic [1:0] pi, pj, pk;
  logic [DW-1:0] tol_w, mv1, mv2, mm;
  logic signed [DW-1:0] xq, yq, ca, cb, lim, crnd;
  logic signed [WW-1:0] rnd, shr;

  logic mul_go, mul_done;
  logic signed [DW-1:0] mul_a, mul_b;
  logic [WW-1:0] mul_p;
  logic div_go, div_done;
  logic [WW-1:0] div_n;
  logic [DW-1:0] div_d;
  logic signed [DW-1:0] div_q;
  logic sq_go, sq_done;
  logic [DW-1:0] sq_root;

  function automatic logic [DW-1:0] mag64(input logic signed [DW-1:0] x);
    return x[DW-1] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic signed [DW-1:0] half64(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] y;
    y = x + $signed({63'd0, x[DW-1]});
    return y >>> 1;
  endfunction

  function automatic logic signed [DW-1:0] clamp64(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] l);
    if (x > l) return l;
    else if (x < -l) return -l;
    else return x;
  endfunction

  function automatic logic signed [DW-1:0] clampw(input logic signed [WW-1:0] x,
                                                  input logic signed [DW-1:0] l);
    logic signed [WW-1:0] lw;
    lw = $signed({{64{l[DW-1]}}, l});
    if (x > lw) return l;
    else if (x < -lw) return -l;
    else return $signed(x[DW-1:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] y;
    y = clamp64(x, jes3_pkg::OUT_LIM);
    return $signed(y[31:0]);
  endfunction

  function automatic logic signed [WW-1:0] q30(input logic signed [DW-1:0] x);
    logic signed [WW-1:0] y;
    y = $signed({{64{x[DW-1]}}, x});
    return y <<< 30;
  endfunction

  assign pready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign prdata = (paddr[2] == jes3_pkg::REG_SWEEPS) ? {26'd0, max_sweeps} : {1'b0, tol};

  always_comb begin
    pi = jes3_pkg::pair_i(pair);
    pj = jes3_pkg::pair_j(pair);
    pk = jes3_pkg::pair_k(pair);
    tol_w = {25'd0, tol, 8'd0};
    mv1 = mag64(v1);
    mv2 = mag64(v2);
    mm = (mv1 > mv2) ? mv1 : mv2;
    case (cq[2:1])
      2'd0: begin xq = aik; yq = ajk; end
      2'd1: begin xq = wi[0]; yq = wj[0]; end
      2'd2: begin xq = wi[1]; yq = wj[1]; end
      default: begin xq = wi[2]; yq = wj[2]; end
    endcase
    ca = cq[0] ? -s : c;
    cb = cq[0] ? c : s;
    lim = (cq[2:1] == 2'd0) ? jes3_pkg::ENT_LIM : jes3_pkg::VEC_LIM;
    rnd = acc + jes3_pkg::RND_VEC;
    shr = rnd >>> 30;
    crnd = clampw(shr, lim);
  end

  always_comb begin
    mul_go = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_go = 1'b0;
    div_n = '0;
    div_d = '0;
    sq_go = 1'b0;
    case (state)
      S_DD_GO: begin mul_go = 1'b1; mul_a = d; mul_b = d; end
      S_TT_GO: begin mul_go = 1'b1; mul_a = t; mul_b = t; end
      S_AA_GO: begin mul_go = 1'b1; mul_a = aii; mul_b = ajj; end
      S_BB_GO: begin mul_go = 1'b1; mul_a = aij; mul_b = aij; end
      S_VV1_GO: begin mul_go = 1'b1; mul_a = v1; mul_b = v1; end
      S_VV2_GO: begin mul_go = 1'b1; mul_a = v2; mul_b = v2; end
      S_CA_GO: begin mul_go = 1'b1; mul_a = ca; mul_b = xq; end
      S_CB_GO: begin mul_go = 1'b1; mul_a = cb; mul_b = yq; end
      S_SQ1_GO, S_SQ2_GO: sq_go = 1'b1;
      S_DIV1_GO: begin
        div_go = 1'b1;
        div_n = acc;
        div_d = (tr > 0) ? li : lj;
      end
      S_DC_GO: begin div_go = 1'b1; div_n = q30(v1); div_d = nrm; end
      S_DS_GO: begin div_go = 1'b1; div_n = q30(v2); div_d = nrm; end
      default: mul_go = 1'b0;
    endcase
  end

  jes3_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  jes3_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .n(div_n), .d(div_d),
    .done(div_done), .quo(div_q)
  );

  jes3_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_go), .n(acc),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      tol <= '0;
      max_sweeps <= jes3_pkg::SWEEPS_RST;
      sw <= '0;
      pair <= '0;
      ok <= '0;
      cq <= '0;
      any <= 1'b0;
      conv <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == jes3_pkg::REG_TOL) tol <= pwdata[30:0];
        else max_sweeps <= pwdata[5:0];
      end
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            dg[0] <= {{24{entry_00[31]}}, entry_00, 8'd0};
            dg[1] <= {{24{entry_11[31]}}, entry_11, 8'd0};
            dg[2] <= {{24{entry_22[31]}}, entry_22, 8'd0};
            od[2] <= {{24{entry_01[31]}}, entry_01, 8'd0};
            od[1] <= {{24{entry_02[31]}}, entry_02, 8'd0};
            od[0] <= {{24{entry_12[31]}}, entry_12, 8'd0};
            for (int r = 0; r < 3; r++) begin
              for (int k = 0; k < 3; k++) begin
                ev[r][k] <= (r == k) ? jes3_pkg::VEC_ONE : '0;
              end
            end
            sw <= '0;
            pair <= '0;
            ok <= '0;
            any <= 1'b0;
            conv <= 1'b0;
            state <= (max_sweeps == 6'd0) ? S_OUT : S_LOAD;
          end
        end
        S_LOAD: begin
          aii <= dg[pi];
          ajj <= dg[pj];
          aij <= od[pk];
          aik <= od[pj];
          ajk <= od[pi];
          for (int k = 0; k < 3; k++) begin
            wi[k] <= ev[pi][k];
            wj[k] <= ev[pj][k];
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          d <= aii - ajj;
          t <= aij <<< 1;
          tr <= aii + ajj;
          gt <= aii > ajj;
          state <= (mag64(aij) <= tol_w) ? S_NEXT : S_DD_GO;
        end
        S_DD_GO: state <= S_DD_W;
        S_DD_W: if (mul_done) begin
          acc <= $signed(mul_p);
          state <= S_TT_GO;
        end
        S_TT_GO: state <= S_TT_W;
        S_TT_W: if (mul_done) begin
          acc <= acc + $signed(mul_p);
          state <= S_SQ1_GO;
        end
        S_SQ1_GO: state <= S_SQ1_W;
        S_SQ1_W: if (sq_done) begin
          disc <= $signed(sq_root);
          state <= S_AA_GO;
        end
        S_AA_GO: state <= S_AA_W;
        S_AA_W: if (mul_done) begin
          acc <= $signed(mul_p);
          state <= S_BB_GO;
        end
        S_BB_GO: state <= S_BB_W;
        S_BB_W: if (mul_done) begin
          acc <= acc - $signed(mul_p);
          state <= S_EIG;
        end
        S_EIG: begin
          if (tr > 0) li <= clamp64(half64(tr + disc), jes3_pkg::ENT_LIM);
          else lj <= clamp64(half64(tr - disc), jes3_pkg::ENT_LIM);
          state <= S_DIV1_GO;
        end
        S_DIV1_GO: state <= S_DIV1_W;
        S_DIV1_W: if (div_done) begin
          if (tr > 0) lj <= clamp64(div_q, jes3_pkg::ENT_LIM);
          else li <= clamp64(div_q, jes3_pkg::ENT_LIM);
          state <= S_VEC;
        end
        S_VEC: begin
          if (gt) begin
            v1 <= half64(d + disc);
            v2 <= aij;
          end else begin
            v1 <= aij;
            v2 <= half64(disc - d);
          end
          state <= S_NORM;
        end
        S_NORM: begin
          if (mm == 64'd0) begin
            state <= S_COMMIT;
          end else if (mm < jes3_pkg::NORM_LO) begin
            v1 <= v1 <<< 1;
            v2 <= v2 <<< 1;
          end else if (mm >= jes3_pkg::NORM_HI) begin
            v1 <= half64(v1);
            v2 <= half64(v2);
          end else begin
            state <= S_VV1_GO;
          end
        end
        S_VV1_GO: state <= S_VV1_W;
        S_VV1_W: if (mul_done) begin
          acc <= $signed(mul_p);
          state <= S_VV2_GO;
        end
        S_VV2_GO: state <= S_VV2_W;
        S_VV2_W: if (mul_done) begin
          acc <= acc + $signed(mul_p);
          state <= S_SQ2_GO;
        end
        S_SQ2_GO: state <= S_SQ2_W;
        S_SQ2_W: if (sq_done) begin
          nrm <= $signed(sq_root);
          state <= S_DC_GO;
        end
        S_DC_GO: state <= S_DC_W;
        S_DC_W: if (div_done) begin
          c <= div_q;
          state <= S_DS_GO;
        end
        S_DS_GO: state <= S_DS_W;
        S_DS_W: if (div_done) begin
          s <= div_q;
          cq <= '0;
          state <= S_CA_GO;
        end
        S_CA_GO: state <= S_CA_W;
        S_CA_W: if (mul_done) begin
          acc <= $signed(mul_p);
          state <= S_CB_GO;
        end
        S_CB_GO: state <= S_CB_W;
        S_CB_W: if (mul_done) begin
          acc <= acc + $signed(mul_p);
          state <= S_CRND;
        end
        S_CRND: begin
          if (!cq[0]) begin
            tmp <= crnd;
          end else begin
            case (cq[2:1])
              2'd0: begin aik <= tmp; ajk <= crnd; end
              2'd1: begin wi[0] <= tmp; wj[0] <= crnd; end
              2'd2: begin wi[1] <= tmp; wj[1] <= crnd; end
              default: begin wi[2] <= tmp; wj[2] <= crnd; end
            endcase
          end
          cq <= cq + 3'd1;
          state <= (cq == 3'd7) ? S_COMMIT : S_CA_GO;
        end
        S_COMMIT: begin
          dg[pi] <= li;
          dg[pj] <= lj;
          od[pk] <= '0;
          od[pj] <= aik;
          od[pi] <= ajk;
          for (int k = 0; k < 3; k++) begin
            ev[pi][k] <= wi[k];
            ev[pj][k] <= wj[k];
          end
          any <= 1'b1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (pair == 2'd2) begin
            pair <= '0;
            any <= 1'b0;
            if (!any) begin
              conv <= 1'b1;
              state <= S_OUT;
            end else if ({1'b0, sw} + 7'd1 == {1'b0, max_sweeps}) begin
              state <= S_OUT;
            end else begin
              sw <= sw + 6'd1;
              state <= S_LOAD;
            end
          end else begin
            pair <= pair + 2'd1;
            state <= S_LOAD;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            pair_index <= ok;
            eigenvalue <= sat32((dg[ok] + jes3_pkg::RND_OUT) >>> 8);
            vector_x <= sat32(ev[ok][0]);
            vector_y <= sat32(ev[ok][1]);
            vector_z <= sat32(ev[ok][2]);
            converged <= conv;
            last <= (ok == 2'd2);
            if (ok == 2'd2) begin
              ok <= '0;
              state <= S_IDLE;
            end else begin
              ok <= ok + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> pair_index == 2'd2)
    else $error("last flag on a result other than the third");

  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> pair != 2'd3)
    else $error("rotation pair out of range");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_LOAD || state == S_OUT)
    else $error("input transfer did not start a matrix");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] e00, e11, e22, e01, e02, e12;
  } matrix_t;

  typedef struct {
    logic [1:0]         pair_index;
    logic signed [31:0] eigenvalue;
    logic signed [31:0] vx, vy, vz;
    logic               converged;
    logic               last;
  } eigenpair_t;

  localparam logic [jes3_pkg::PAW-1:0] ADDR_TOL    = 0;
  localparam logic [jes3_pkg::PAW-1:0] ADDR_SWEEPS = 4;
  localparam logic [63:0] SAT62    = 64'd1 << 62;
  localparam longint      ENT_MAX  = (64'sd1 <<< 45) - 1;
  localparam longint      VEC_MAX  = 64'sd1 <<< 40;
  localparam longint      UNIT_VEC = 64'sd1 <<< 30;
  localparam logic [63:0] NORM_FLOOR = 64'd1 << 44;
  localparam int          LIMIT_CYCLES = 30000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] entry_00 = 0, entry_11 = 0, entry_22 = 0;
  logic signed [31:0] entry_01 = 0, entry_02 = 0, entry_12 = 0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] pair_index;
  logic signed [31:0] eigenvalue, vector_x, vector_y, vector_z;
  logic converged, last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [jes3_pkg::PAW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  jacobi_eigen_sym3 u_top (.*);

  always #6 clk = ~clk;

  matrix_t    pending_q[$];
  eigenpair_t eigenpair_q[$];
  int         error_count = 0;
  logic [30:0] tol_reg = 0;
  logic [5:0]  sweeps_reg = 6'd16;
  longint     mtx[3][3];
  longint     evec[3][3];

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint from_mag(logic neg, logic [63:0] m);
    if (m > SAT62) m = SAT62;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clampv(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic wide_t wmul(longint a, longint b);
    wide_t wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic longint wsat(wide_t x);
    logic [127:0] m;
    m = x[127] ? -x : x;
    return from_mag(x[127], m[127:64] != 0 ? SAT62 : m[63:0]);
  endfunction

  function automatic longint shr_round(wide_t x, int sh);
    wide_t one;
    one = 1;
    x = x + (one <<< (sh - 1));
    x = x >>> sh;
    return wsat(x);
  endfunction

  function automatic longint div_round(wide_t n, longint d);
    logic [127:0] nm, q, dm;
    logic neg;
    if (d == 0) return 0;
    neg = n[127] != (d < 0);
    nm = n[127] ? -n : n;
    dm = {64'd0, mag(d)};
    nm = nm + (dm >> 1);
    q = nm / dm;
    return from_mag(neg, q[127:64] != 0 ? SAT62 : q[63:0]);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r, c;
    logic [127:0] p;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      p = {64'd0, c} * {64'd0, c};
      if (p <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint comb(longint c, longint a, longint s, longint b, longint lim);
    return clampv(shr_round(wmul(c, a) + wmul(s, b), 30), lim);
  endfunction

  function automatic logic rotate_pair(int i, int j, logic [63:0] tol);
    longint aii, ajj, aij, d, t, disc, tr, li, lj, v1, v2, c, s, aik, ajk, eik, ejk;
    logic [63:0] m, nrm;
    wide_t det;
    aii = mtx[i][i];
    ajj = mtx[j][j];
    aij = mtx[i][j];
    if (mag(aij) <= tol) return 1'b0;
    d = aii - ajj;
    t = 2 * aij;
    disc = longint'(isqrt(wmul(d, d) + wmul(t, t)));
    tr = aii + ajj;
    det = wmul(aii, ajj) - wmul(aij, aij);
    if (tr > 0) begin
      li = clampv((tr + disc) / 2, ENT_MAX);
      lj = clampv(div_round(det, li), ENT_MAX);
    end else begin
      lj = clampv((tr - disc) / 2, ENT_MAX);
      li = clampv(div_round(det, lj), ENT_MAX);
    end
    mtx[i][i] = li;
    mtx[j][j] = lj;
    mtx[i][j] = 0;
    mtx[j][i] = 0;
    if (aii > ajj) begin
      v1 = (d + disc) / 2;
      v2 = aij;
    end else begin
      v1 = aij;
      v2 = (disc - d) / 2;
    end
    m = mag(v1) > mag(v2) ? mag(v1) : mag(v2);
    if (m == 0) return 1'b1;
    while (m < NORM_FLOOR) begin
      v1 = v1 * 2;
      v2 = v2 * 2;
      m = m * 2;
    end
    while (m >= 2 * NORM_FLOOR) begin
      v1 = v1 / 2;
      v2 = v2 / 2;
      m = m / 2;
    end
    nrm = isqrt(wmul(v1, v1) + wmul(v2, v2));
    c = div_round(wmul(v1, UNIT_VEC), longint'(nrm));
    s = div_round(wmul(v2, UNIT_VEC), longint'(nrm));
    for (int k = 0; k < 3; k++) begin
      if (k != i && k != j) begin
        aik = mtx[i][k];
        ajk = mtx[j][k];
        mtx[i][k] = comb(c, aik, s, ajk, ENT_MAX);
        mtx[k][i] = mtx[i][k];
        mtx[j][k] = comb(-s, aik, c, ajk, ENT_MAX);
        mtx[k][j] = mtx[j][k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      eik = evec[i][k];
      ejk = evec[j][k];
      evec[i][k] = comb(c, eik, s, ejk, VEC_MAX);
      evec[j][k] = comb(-s, eik, c, ejk, VEC_MAX);
    end
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] to_out32(longint v);
    longint cl;
    cl = clampv(v, 64'sd2147483647);
    return cl[31:0];
  endfunction

  function automatic void diagonalize(matrix_t mx);
    logic [63:0] tol;
    logic conv, any;
    eigenpair_t ep;
    wide_t wv;
    tol = {33'd0, tol_reg} << 8;
    conv = 1'b0;
    mtx[0][0] = longint'(mx.e00) * 256;
    mtx[1][1] = longint'(mx.e11) * 256;
    mtx[2][2] = longint'(mx.e22) * 256;
    mtx[0][1] = longint'(mx.e01) * 256;
    mtx[1][0] = mtx[0][1];
    mtx[0][2] = longint'(mx.e02) * 256;
    mtx[2][0] = mtx[0][2];
    mtx[1][2] = longint'(mx.e12) * 256;
    mtx[2][1] = mtx[1][2];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        evec[r][c] = (r == c) ? UNIT_VEC : 0;
    for (int sw = 0; sw < sweeps_reg; sw++) begin
      any = 1'b0;
      if (rotate_pair(1, 0, tol)) any = 1'b1;
      if (rotate_pair(2, 0, tol)) any = 1'b1;
      if (rotate_pair(2, 1, tol)) any = 1'b1;
      if (!any) begin
        conv = 1'b1;
        break;
      end
    end
    for (int k = 0; k < 3; k++) begin
      wv = mtx[k][k];
      ep.pair_index = k[1:0];
      ep.eigenvalue = to_out32(shr_round(wv, 8));
      ep.vx = to_out32(evec[k][0]);
      ep.vy = to_out32(evec[k][1]);
      ep.vz = to_out32(evec[k][2]);
      ep.converged = conv;
      ep.last = (k == 2);
      eigenpair_q.push_back(ep);
    end
  endfunction

  // sender: bursts and gaps
  logic taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !taken)) begin
      taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        entry_00 <= pending_q[0].e00;
        entry_11 <= pending_q[0].e11;
        entry_22 <= pending_q[0].e22;
        entry_01 <= pending_q[0].e01;
        entry_02 <= pending_q[0].e02;
        entry_12 <= pending_q[0].e12;
        in_valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 8);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_left = 0;
  logic stall_now = 1'b0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          stall_now = 1'b0;
          stall_left = $urandom_range(20, 200);
        end
        1: begin
          stall_now = 1'b1;
          stall_left = $urandom_range(1, 40);
        end
        default: begin
          stall_now = ~stall_now;
          stall_left = $urandom_range(1, 4);
        end
      endcase
    end
    stall_left--;
    out_stall <= rst ? 1'b0 : stall_now;
  end

  // input transfer prediction and result checking
  eigenpair_t exp_ep;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall && pending_q.size() > 0) begin
      diagonalize(pending_q[0]);
      void'(pending_q.pop_front());
      taken = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (eigenpair_q.size() == 0) begin
        $error("unexpected result transfer, pair_index %0d", pair_index);
        error_count++;
      end else begin
        exp_ep = eigenpair_q.pop_front();
        if (pair_index !== exp_ep.pair_index) begin
          $error("pair_index exp %0d got %0d", exp_ep.pair_index, pair_index);
          error_count++;
        end
        if (eigenvalue !== exp_ep.eigenvalue) begin
          $error("eigenvalue exp %0d got %0d", exp_ep.eigenvalue, eigenvalue);
          error_count++;
        end
        if (vector_x !== exp_ep.vx) begin
          $error("vector_x exp %0d got %0d", exp_ep.vx, vector_x);
          error_count++;
        end
        if (vector_y !== exp_ep.vy) begin
          $error("vector_y exp %0d got %0d", exp_ep.vy, vector_y);
          error_count++;
        end
        if (vector_z !== exp_ep.vz) begin
          $error("vector_z exp %0d got %0d", exp_ep.vz, vector_z);
          error_count++;
        end
        if (converged !== exp_ep.converged) begin
          $error("converged exp %0d got %0d", exp_ep.converged, converged);
          error_count++;
        end
        if (last !== exp_ep.last) begin
          $error("last exp %0d got %0d", exp_ep.last, last);
          error_count++;
        end
      end
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic apb_write(logic [jes3_pkg::PAW-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_TOL) tol_reg = data[30:0];
    else sweeps_reg = data[5:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_entry();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 0;
          default: return -1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $signed($urandom_range(0, 2 ** 21)) - (2 ** 20);
    endcase
  endfunction

  function automatic matrix_t make_matrix(logic signed [31:0] a00, logic signed [31:0] a11,
                                          logic signed [31:0] a22, logic signed [31:0] a01,
                                          logic signed [31:0] a02, logic signed [31:0] a12);
    matrix_t mx;
    mx.e00 = a00;
    mx.e11 = a11;
    mx.e22 = a22;
    mx.e01 = a01;
    mx.e02 = a02;
    mx.e12 = a12;
    return mx;
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || eigenpair_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_random(logic [30:0] tol, logic [5:0] sweeps, int count);
    apb_write(ADDR_TOL, {1'b0, tol});
    apb_write(ADDR_SWEEPS, {26'd0, sweeps});
    for (int n = 0; n < count; n++)
      pending_q.push_back(make_matrix(pick_entry(), pick_entry(), pick_entry(),
                                      pick_entry(), pick_entry(), pick_entry()));
    drain();
  endtask

  localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] NMAX = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: tolerance zero, 16 sweeps
    pending_q.push_back(make_matrix(0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_matrix(ONE, ONE, ONE, 0, 0, 0));
    pending_q.push_back(make_matrix(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX));
    pending_q.push_back(make_matrix(NMAX, NMAX, NMAX, NMAX, NMAX, NMAX));
    pending_q.push_back(make_matrix(PMAX, NMAX, 0, PMAX, NMAX, PMAX));
    pending_q.push_back(make_matrix(NMAX, PMAX, -1, NMAX, PMAX, NMAX));
    pending_q.push_back(make_matrix(0, 0, 0, ONE, 0, 0));
    pending_q.push_back(make_matrix(0, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_matrix(0, 0, 0, 0, 0, ONE));
    pending_q.push_back(make_matrix(ONE, ONE, ONE, ONE, ONE, ONE));
    pending_q.push_back(make_matrix(-ONE, -ONE, -ONE, ONE, -ONE, ONE));
    pending_q.push_back(make_matrix(2 * ONE, ONE, -ONE, -ONE, ONE, -ONE));
    pending_q.push_back(make_matrix(-5 * ONE, 3 * ONE, 0, 1, -1, 1));
    pending_q.push_back(make_matrix(-1, -1, -1, -1, -1, -1));
    pending_q.push_back(make_matrix(1, 2, 3, 1, 1, 1));
    pending_q.push_back(make_matrix(0, 0, 0, NMAX, NMAX, NMAX));
    pending_q.push_back(make_matrix(PMAX, 0, NMAX, 0, 0, 0));
    pending_q.push_back(make_matrix(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F,
                                    32'shF0F0F0F0, 32'sh33333333, 32'shCCCCCCCC));
    drain();

    // sweep limit zero: diagonal passes through
    apb_write(ADDR_SWEEPS, 32'd0);
    pending_q.push_back(make_matrix(PMAX, NMAX, ONE, ONE, ONE, ONE));
    drain();
    run_random(31'd0, 6'd0, 4);
    run_random(31'd0, 6'd1, 60);
    run_random(31'd0, 6'd2, 50);
    run_random(31'h10, 6'd3, 50);
    // largest tolerance: nothing rotates unless an off-diagonal entry is the most negative value
    run_random(31'h7FFFFFFF, 6'd63, 30);
    run_random(31'($urandom_range(1, 2 ** 20)), 6'd4, 40);
    run_random(31'd0, 6'd63, 4);
    run_random(31'($urandom_range(0, 255)), 6'd6, 30);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
